// File: rtl/spq_pkg.sv
`default_nettype none
package spq_pkg;

  localparam int DEPTH  = 16;
  localparam int LEVELS = 4;
  localparam int CODE_W = 40;
  localparam int PRIO_W = 3;
  localparam int FILL_W = 5;
  localparam int STAT_W = 2;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [CNT_W-1:0]  DEPTH_CNT   = CNT_W'(DEPTH);
  localparam logic [PRIO_W-1:0] PRIO_TOP    = PRIO_W'(1);
  localparam logic [PRIO_W-1:0] PRIO_BOTTOM = PRIO_W'(LEVELS);

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_REMOVED  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic             ins;
    logic             rem;
    entry_t           new_entry;
    logic [CNT_W-1:0] count;
  } cell_ctl_t;

endpackage
`default_nettype wire

// File: rtl/spq_cell.sv
`default_nettype none
module spq_cell (
  input  wire                      clk,
  input  wire spq_pkg::cell_ctl_t  ctl,
  input  wire [spq_pkg::IDX_W-1:0] idx,
  input  wire                      keep_prev,
  input  wire spq_pkg::entry_t     prev_entry,
  input  wire spq_pkg::entry_t     next_entry,
  output logic                     keep,
  output spq_pkg::entry_t          entry
);
  import spq_pkg::*;

  entry_t entry_next;
  logic   occupied;

  assign occupied = CNT_W'(idx) < ctl.count;
  // cells ahead of the insert point keep their entry; order is sorted so this is a prefix
  assign keep = occupied && (entry.prio <= ctl.new_entry.prio);

  always_comb begin
    entry_next = entry;
    if (ctl.ins) begin
      if (keep) begin
        entry_next = entry;
      end else if (keep_prev) begin
        entry_next = ctl.new_entry;
      end else begin
        entry_next = prev_entry;
      end
    end else if (ctl.rem) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire

// File: rtl/four_level_stable_priority_queue.sv
`default_nettype none
// Stable four-level priority queue of ticket entries.
// Command channel: a transaction is taken at a rising edge where start is high
// and busy is low. busy is always low: one transaction can be issued per cycle.
// action 0 inserts ticket_code with priority_req (0 is taken as 1, above 4 as
// 4); the entry goes behind every held entry of equal or better priority.
// action 1 removes the head entry (lowest priority number, oldest first).
// Result channel: exactly one result per transaction, shown for one cycle with
// done high, in the cycle after the transaction is taken (throughput 1
// transaction per cycle). status gives inserted, removed, remove on empty, or
// insert dropped because full; fill_count is the count afterwards.
// The entries live in a row of DEPTH cells; on an insert the cells behind the
// insert point shift toward the tail, on a remove all shift toward the head, in
// the same cycle, so the rate does not depend on the fill.
// The receiver cannot stall; results must be taken when done is high.
// Reset (rst, synchronous) empties the queue and clears done; entry contents
// are not cleared and are never shown before being written.
module four_level_stable_priority_queue (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  output logic                       busy,
  input  wire                        action,
  input  wire [spq_pkg::CODE_W-1:0]  ticket_code,
  input  wire [spq_pkg::PRIO_W-1:0]  priority_req,
  output logic                       done,
  output logic [spq_pkg::CODE_W-1:0] out_code,
  output logic [spq_pkg::PRIO_W-1:0] out_priority,
  output logic [spq_pkg::STAT_W-1:0] status,
  output logic [spq_pkg::FILL_W-1:0] fill_count
);
  import spq_pkg::*;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [PRIO_W-1:0] prio_sat;
  logic              take;
  logic              ins_ok;
  logic              rem_ok;
  logic [STAT_W-1:0] status_next;
  cell_ctl_t         ctl;

  entry_t cell_entry [DEPTH];
  logic   cell_keep  [DEPTH];

  assign busy = 1'b0;
  assign take = start && !busy;

  always_comb begin
    prio_sat = priority_req;
    if (priority_req < PRIO_TOP) begin
      prio_sat = PRIO_TOP;
    end else if (priority_req > PRIO_BOTTOM) begin
      prio_sat = PRIO_BOTTOM;
    end
  end

  assign ins_ok = take && (action == ACT_INSERT) && (count != DEPTH_CNT);
  assign rem_ok = take && (action == ACT_REMOVE) && (count != '0);

  assign ctl.ins            = ins_ok;
  assign ctl.rem            = rem_ok;
  assign ctl.new_entry.code = ticket_code;
  assign ctl.new_entry.prio = prio_sat;
  assign ctl.count          = count;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      spq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .idx        (IDX_W'(g)),
        .keep_prev  ((g == 0) ? 1'b1 : cell_keep[(g == 0) ? 0 : g - 1]),
        .prev_entry ((g == 0) ? entry_t'('0) : cell_entry[(g == 0) ? 0 : g - 1]),
        .next_entry ((g == DEPTH - 1) ? entry_t'('0)
                                      : cell_entry[(g == DEPTH - 1) ? g : g + 1]),
        .keep       (cell_keep[g]),
        .entry      (cell_entry[g])
      );
    end
  endgenerate

  always_comb begin
    count_next  = count;
    status_next = ST_INSERTED;
    if (action == ACT_INSERT) begin
      if (ins_ok) begin
        count_next  = count + CNT_W'(1);
        status_next = ST_INSERTED;
      end else begin
        status_next = ST_FULL;
      end
    end else begin
      if (rem_ok) begin
        count_next  = count - CNT_W'(1);
        status_next = ST_REMOVED;
      end else begin
        status_next = ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= take;
      if (take) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status     <= status_next;
      fill_count <= FILL_W'(count_next);
      if (rem_ok) begin
        out_code     <= cell_entry[0].code;
        out_priority <= cell_entry[0].prio;
      end else begin
        out_code     <= '0;
        out_priority <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/spq_checker.sv
`default_nettype none
module spq_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        start,
  input wire                        busy,
  input wire                        done,
  input wire [spq_pkg::CODE_W-1:0]  out_code,
  input wire [spq_pkg::PRIO_W-1:0]  out_priority,
  input wire [spq_pkg::STAT_W-1:0]  status,
  input wire [spq_pkg::FILL_W-1:0]  fill_count
);
  import spq_pkg::*;

  // one result per transaction, in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("no result after accepted transaction");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result without transaction");

  a_removed_prio: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_REMOVED) |-> (out_priority >= PRIO_TOP && out_priority <= PRIO_BOTTOM))
    else $error("removed entry has bad priority");

  a_no_payload: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_REMOVED) |-> (out_code == '0 && out_priority == '0))
    else $error("payload on non-remove result");

  a_empty_fill: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (fill_count == '0))
    else $error("empty remove with nonzero fill");

endmodule

bind four_level_stable_priority_queue spq_checker u_spq_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .out_code     (out_code),
  .out_priority (out_priority),
  .status       (status),
  .fill_count   (fill_count)
);
`default_nettype wire

// File: test/testbench.sv
`default_nettype none
module testbench;
  import spq_pkg::*;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [PRIO_W-1:0] prio;
    logic [STAT_W-1:0] stat;
    logic [FILL_W-1:0] fill;
  } ticket_result_t;

  // one row of the directed table; want is used only when pinned is set
  typedef struct packed {
    logic              act;
    logic [CODE_W-1:0] code;
    logic [PRIO_W-1:0] prio;
    logic              pinned;
    ticket_result_t    want;
  } stim_row_t;

  localparam ticket_result_t UNPINNED = '0;
  localparam int N_DIRECTED = 25;
  localparam int N_RANDOM = 1150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic action = ACT_INSERT;
  logic [CODE_W-1:0] ticket_code = '0;
  logic [PRIO_W-1:0] priority_req = '0;
  logic pin_en = 1'b0;
  ticket_result_t pin_res = '0;

  logic busy;
  logic done;
  logic [CODE_W-1:0] out_code;
  logic [PRIO_W-1:0] out_priority;
  logic [STAT_W-1:0] status;
  logic [FILL_W-1:0] fill_count;

  // predictor state: entries in service order from the head
  entry_t held[DEPTH];
  int held_count = 0;

  ticket_result_t expected_q[$];
  int mismatch_count = 0;
  int n_ops = 0, n_inserted = 0, n_removed = 0, n_full = 0, n_empty = 0, n_clamped = 0;

  four_level_stable_priority_queue DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .ticket_code  (ticket_code),
    .priority_req (priority_req),
    .done         (done),
    .out_code     (out_code),
    .out_priority (out_priority),
    .status       (status),
    .fill_count   (fill_count)
  );

  initial forever #6 clk = ~clk;

  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

  function automatic ticket_result_t predict_ticket(logic act, logic [CODE_W-1:0] code,
                                                    logic [PRIO_W-1:0] prio);
    ticket_result_t r;
    logic [PRIO_W-1:0] level;
    int pos;
    int k;
    r = '0;
    if (act == ACT_INSERT) begin
      if (held_count >= DEPTH) begin
        r.stat = ST_FULL;
      end else begin
        if (prio < PRIO_TOP) level = PRIO_TOP;
        else if (prio > PRIO_BOTTOM) level = PRIO_BOTTOM;
        else level = prio;
        // new entry goes behind every entry of equal or better level
        pos = 0;
        while (pos < held_count && held[pos].prio <= level) pos++;
        for (k = held_count; k > pos; k--) held[k] = held[k-1];
        held[pos] = {code, level};
        held_count++;
        r.stat = ST_INSERTED;
      end
    end else begin
      if (held_count == 0) begin
        r.stat = ST_EMPTY;
      end else begin
        r.code = held[0].code;
        r.prio = held[0].prio;
        for (k = 1; k < held_count; k++) held[k-1] = held[k];
        held_count--;
        r.stat = ST_REMOVED;
      end
    end
    r.fill = FILL_W'(held_count);
    return r;
  endfunction

  task automatic flag_error(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("ERROR: %s", msg);
  endtask

  // accept side and result side, both sampled on the pre-edge values
  always @(posedge clk) begin
    ticket_result_t pred;
    ticket_result_t want;
    if (!rst) begin
      if (start && !busy) begin
        pred = predict_ticket(action, ticket_code, priority_req);
        n_ops++;
        case (pred.stat)
          ST_INSERTED: n_inserted++;
          ST_REMOVED:  n_removed++;
          ST_EMPTY:    n_empty++;
          default:     n_full++;
        endcase
        if (action == ACT_INSERT && pred.stat == ST_INSERTED &&
            (priority_req < PRIO_TOP || priority_req > PRIO_BOTTOM))
          n_clamped++;
        expected_q.push_back(pin_en ? pin_res : pred);
      end
      if (done) begin
        if (expected_q.size() == 0) begin
          flag_error($sformatf({"result with no transaction pending: ",
                                "code %h prio %0d status %0d fill %0d"},
                               out_code, out_priority, status, fill_count));
        end else begin
          want = expected_q.pop_front();
          if (out_code !== want.code || out_priority !== want.prio ||
              status !== want.stat || fill_count !== want.fill)
            flag_error($sformatf({"expected code %h prio %0d status %0d fill %0d, ",
                                  "got code %h prio %0d status %0d fill %0d"},
                                 want.code, want.prio, want.stat, want.fill,
                                 out_code, out_priority, status, fill_count));
        end
      end
    end
  end

  task automatic drive_op(logic act, logic [CODE_W-1:0] code, logic [PRIO_W-1:0] prio,
                          logic pinned, ticket_result_t want);
    start <= 1'b1;
    action <= act;
    ticket_code <= code;
    priority_req <= prio;
    pin_en <= pinned;
    pin_res <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic stim_row_t directed_row(int idx);
    case (idx)
      0:  return {ACT_REMOVE, 40'h0, 3'd0, 1'b1, 40'h0, 3'd0, ST_EMPTY, 5'd0};
      1:  return {ACT_INSERT, 40'hFF_FFFF_FFFF, 3'd4, 1'b1, 40'h0, 3'd0, ST_INSERTED, 5'd1};
      2:  return {ACT_INSERT, 40'h00_0000_0000, 3'd1, 1'b1, 40'h0, 3'd0, ST_INSERTED, 5'd2};
      3:  return {ACT_REMOVE, 40'hFF_FFFF_FFFF, 3'd7, 1'b1, 40'h0, 3'd1, ST_REMOVED, 5'd1};
      4:  return {ACT_INSERT, 40'h01_2345_6789, 3'd0, 1'b0, UNPINNED};
      5:  return {ACT_INSERT, 40'hAA_AAAA_AAAA, 3'd7, 1'b0, UNPINNED};
      6:  return {ACT_INSERT, 40'h55_5555_5555, 3'd2, 1'b0, UNPINNED};
      7:  return {ACT_INSERT, 40'h80_0000_0001, 3'd3, 1'b0, UNPINNED};
      8:  return {ACT_INSERT, 40'h12_3456_789A, 3'd1, 1'b0, UNPINNED};
      9:  return {ACT_INSERT, 40'hFE_DCBA_9876, 3'd5, 1'b0, UNPINNED};
      10: return {ACT_INSERT, 40'h00_0000_0001, 3'd6, 1'b0, UNPINNED};
      11: return {ACT_INSERT, 40'h11_1111_1111, 3'd1, 1'b0, UNPINNED};
      12: return {ACT_INSERT, 40'h22_2222_2222, 3'd2, 1'b0, UNPINNED};
      13: return {ACT_INSERT, 40'h33_3333_3333, 3'd3, 1'b0, UNPINNED};
      14: return {ACT_INSERT, 40'h44_4444_4444, 3'd4, 1'b0, UNPINNED};
      15: return {ACT_INSERT, 40'h66_6666_6666, 3'd2, 1'b0, UNPINNED};
      16: return {ACT_INSERT, 40'h77_7777_7777, 3'd1, 1'b0, UNPINNED};
      17: return {ACT_INSERT, 40'h99_9999_9999, 3'd3, 1'b0, UNPINNED};
      18: return {ACT_INSERT, 40'hCC_CCCC_CCCC, 3'd4, 1'b0, UNPINNED};
      // queue holds DEPTH entries now
      19: return {ACT_INSERT, 40'hDE_ADBE_EF00, 3'd2, 1'b1, 40'h0, 3'd0, ST_FULL, 5'd16};
      20: return {ACT_INSERT, 40'hFF_FFFF_FFFF, 3'd0, 1'b1, 40'h0, 3'd0, ST_FULL, 5'd16};
      21: return {ACT_REMOVE, 40'h0, 3'd0, 1'b0, UNPINNED};
      22: return {ACT_REMOVE, 40'hFF_FFFF_FFFF, 3'd7, 1'b0, UNPINNED};
      23: return {ACT_REMOVE, 40'h0, 3'd4, 1'b0, UNPINNED};
      default: return {ACT_REMOVE, 40'h0, 3'd1, 1'b0, UNPINNED};
    endcase
  endfunction

  task automatic run_random(int n_items);
    int sent;
    int burst_len;
    int ins_pct;
    int i;
    logic act;
    logic [CODE_W-1:0] code;
    logic [PRIO_W-1:0] prio;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 7) == 0) burst_len = $urandom_range(60, 150);
      else burst_len = $urandom_range(1, 24);
      // bias each burst toward filling, draining or a mix so full and empty both get hit
      case ($urandom_range(0, 2))
        0:       ins_pct = 80;
        1:       ins_pct = 20;
        default: ins_pct = 50;
      endcase
      for (i = 0; i < burst_len && sent < n_items; i++) begin
        act = ($urandom_range(0, 99) < ins_pct) ? ACT_INSERT : ACT_REMOVE;
        case ($urandom_range(0, 7))
          0:       code = '0;
          1:       code = '1;
          default: code = {8'($urandom), 32'($urandom)};
        endcase
        if ($urandom_range(0, 99) < 85) prio = PRIO_W'($urandom_range(1, 4));
        else prio = PRIO_W'($urandom_range(0, 7));
        drive_op(act, code, prio, 1'b0, UNPINNED);
        sent++;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: ;
        3:       wait_drained();
        default: idle($urandom_range(1, 8));
      endcase
    end
  endtask

  initial begin
    stim_row_t row;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    idle(2);
    for (int r = 0; r < N_DIRECTED; r++) begin
      row = directed_row(r);
      drive_op(row.act, row.code, row.prio, row.pinned, row.want);
    end
    wait_drained();
    run_random(N_RANDOM);
    wait_drained();
    repeat (4) @(posedge clk);
    $display("%0d transactions: %0d inserts (%0d with clamped priority), %0d removes,",
             n_ops, n_inserted, n_clamped, n_removed);
    $display("%0d inserts dropped on full queue, %0d removes on empty queue", n_full, n_empty);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/four_level_stable_priority_queue.sv
rtl/spq_checker.sv
test/testbench.sv
